FILE: hdl/framebuffer_pixel_rect_fill_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the framebuffer rectangle fill core
// Concurrent checks that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_PIXEL_RECT_FILL_CORE_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_RECT_FILL_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, off while reset is held.
`define FBRF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fbrf assertion failed");

// Clocked check that also holds during reset.
`define FBRF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fbrf assertion failed");

`else

`define FBRF_ASSERT(lbl, clk, rst_n, prop)
`define FBRF_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: hdl/fbrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_pkg
// Shared types and codes of the framebuffer rectangle fill core.
// ----------------------------------------------------------------------------
package fbrf_pkg;

    localparam int X_MAX_DEF = 175;
    localparam int Y_MAX_DEF = 175;

    localparam int COORD_W = 8;
    localparam int COLOR_W = 4;

    // request opcodes
    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_FILL = 2'd2;

    // pixel_mode codes; anything else is the no-op mode
    localparam logic [1:0] MODE_NIBBLE = 2'd0;
    localparam logic [1:0] MODE_BIT    = 2'd1;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [COLOR_W-1:0] pixel_color;
    } t_req;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic               rejected;
    } t_rsp;

endpackage

FILE: hdl/framebuffer_pixel_rect_fill_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_pixel_rect_fill_core
// Framebuffer with dot draw, dot read and rectangle fill over two stores.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for a single cycle with o_done high; the result
// cannot be held off, so the receiver must take it in that cycle. A dot draw,
// an off-screen dot read, a rejected or empty fill and an undefined op are
// answered from the decode state; an on-screen dot read also passes through
// the read-wait state for the registered RAM read; and a fill that draws
// walks its W*H pixels one per cycle, since the fill walker and the shared
// address unit (row times width plus column) handle one pixel each cycle on
// the single port of each store. busy is low again in the cycle the result is
// shown. The pixel stores come up undefined: reading a pixel never written
// returns garbage. pixel_mode is written through the config channel, which
// is ready only while no request is in flight.
// ----------------------------------------------------------------------------
`include "framebuffer_pixel_rect_fill_core_assert.svh"

module framebuffer_pixel_rect_fill_core #(
    parameter int X_MAX = fbrf_pkg::X_MAX_DEF,
    parameter int Y_MAX = fbrf_pkg::Y_MAX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // request channel
    input  logic           start,
    output logic           busy,
    input  fbrf_pkg::t_req i_req,
    // result strobe
    output logic           o_done,
    output fbrf_pkg::t_rsp o_rsp,
    // pixel_mode write channel
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_data
);

    import fbrf_pkg::*;

    localparam int COLS   = X_MAX + 1;
    localparam int ROWS   = Y_MAX + 1;
    localparam int DEPTH  = COLS * ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [COORD_W-1:0] XM = COORD_W'(X_MAX);
    localparam logic [COORD_W-1:0] YM = COORD_W'(Y_MAX);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,    // decode, range check, dot write or read issue
        ST_RDWAIT,  // registered read data is back
        ST_FILL     // one pixel per cycle, column outer, row inner
    } t_state;

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    logic [COORD_W-1:0] r_x, n_x;       // fill / dot column
    logic [COORD_W-1:0] r_y, n_y;       // fill / dot row
    logic [1:0]         r_mode, n_mode;
    logic               r_done, n_done;
    t_rsp               r_rsp, n_rsp;

    logic               w_on_start;
    logic               w_on_end;
    logic               w_wr;
    logic [ADDR_W-1:0]  w_addr;
    logic [COLOR_W-1:0] w_nib_rdata;
    logic [0:0]         w_bit_rdata;

    // shared address unit: every access of both stores goes through here
    assign w_addr = ADDR_W'(r_y) * ADDR_W'(COLS) + ADDR_W'(r_x);

    assign w_on_start = (r_x <= XM) && (r_y <= YM);
    assign w_on_end   = (r_req.x_end <= XM) && (r_req.y_end <= YM);

    // pixel write: an on-screen dot draw, or any step of a running fill
    assign w_wr = ((r_state == ST_EXEC) && (r_req.op == OP_DRAW) && w_on_start)
               || (r_state == ST_FILL);

    fbrf_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_nibble_store (
        .i_clk   (i_clk),
        .i_we    (w_wr && (r_mode == MODE_NIBBLE)),
        .i_addr  (w_addr),
        .i_wdata (r_req.pixel_color),
        .o_rdata (w_nib_rdata)
    );

    fbrf_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_bit_store (
        .i_clk   (i_clk),
        .i_we    (w_wr && (r_mode == MODE_BIT)),
        .i_addr  (w_addr),
        .i_wdata (r_req.pixel_color[0]),
        .o_rdata (w_bit_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_x     = r_x;
        n_y     = r_y;
        n_mode  = r_mode;
        n_done  = 1'b0;
        n_rsp   = r_rsp;

        if (i_cfg_valid && o_cfg_ready) begin
            n_mode = i_cfg_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_x     = i_req.x_start;
                    n_y     = i_req.y_start;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_rsp   = '0;
                n_done  = 1'b1;
                n_state = ST_IDLE;
                priority if (r_req.op == OP_DRAW) begin
                    n_rsp.rejected = !w_on_start;
                end else if (r_req.op == OP_READ) begin
                    if (w_on_start) begin
                        // read issued this cycle, answer comes next
                        n_done  = 1'b0;
                        n_state = ST_RDWAIT;
                    end else begin
                        n_rsp.rejected = 1'b1;
                    end
                end else if (r_req.op == OP_FILL) begin
                    if (!w_on_start || !w_on_end) begin
                        n_rsp.rejected = 1'b1;
                    end else if ((r_x <= r_req.x_end) && (r_y <= r_req.y_end)) begin
                        n_done  = 1'b0;
                        n_state = ST_FILL;
                    end
                end else begin
                    // undefined op: empty result
                end
            end
            ST_RDWAIT: begin
                n_rsp = '0;
                unique case (r_mode)
                    MODE_NIBBLE: n_rsp.read_color = w_nib_rdata;
                    MODE_BIT:    n_rsp.read_color = COLOR_W'(w_bit_rdata);
                    default:     n_rsp.read_color = '0;
                endcase
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_FILL: begin
                if (r_y == r_req.y_end) begin
                    if (r_x == r_req.x_end) begin
                        n_rsp   = '0;
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_x = r_x + 1'b1;
                        n_y = r_req.y_start;
                    end
                end else begin
                    n_y = r_y + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_x     <= '0;
            r_y     <= '0;
            r_mode  <= MODE_NIBBLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
            r_mode  <= n_mode;
            r_done  <= n_done;
        end
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

    // an accepted request always leaves the block busy in the following cycle
    `FBRF_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    // every result closes out work that was in flight
    `FBRF_ASSERT(a_done_after_busy, i_clk, i_rst_n, o_done |-> $past(busy))
    // the fill walker never leaves the rectangle
    `FBRF_ASSERT(a_fill_in_rect, i_clk, i_rst_n,
        (r_state == ST_FILL) |-> ((r_x <= r_req.x_end) && (r_y <= r_req.y_end)))
    // a nonzero color only comes back from a read
    `FBRF_ASSERT(a_color_from_read, i_clk, i_rst_n,
        (o_done && (o_rsp.read_color != '0)) |-> $past(r_state == ST_RDWAIT))
    // config never lands while a request is in flight
    `FBRF_ASSERT_ALWAYS(a_cfg_idle, i_clk, o_cfg_ready |-> !busy)

endmodule

FILE: hdl/fbrf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_ram
// Generic single-port RAM, write-first off, registered read.
// ----------------------------------------------------------------------------
module fbrf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/framebuffer_pixel_rect_fill_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_pixel_rect_fill_core_tb
// Self-checking bench for the framebuffer core. A short table of directed
// requests is run first, then random dot draws, dot reads, rectangle fills
// and undefined ops across all pixel modes. Every result is checked against a
// typed-in value or a behavioral framebuffer kept inside the bench.
// ----------------------------------------------------------------------------
module framebuffer_pixel_rect_fill_core_tb;
    import fbrf_pkg::*;

    localparam int XM    = X_MAX_DEF;
    localparam int YM    = Y_MAX_DEF;
    localparam int COLS  = XM + 1;
    localparam int NPIX  = COLS * (YM + 1);
    localparam int N_RND = 1950;

    // codes the package leaves unnamed
    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam logic [1:0] MODE_TRIBIT = 2'd2;
    localparam logic [1:0] MODE_UNDEF  = 2'd3;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       o_done;
    t_rsp       o_rsp;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data;

    framebuffer_pixel_rect_fill_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Bench copy of the framebuffer. Pixels start as X, as in the core's stores,
    // so a read of a pixel that neither side wrote compares X with X and passes
    // silently. The fill walker position is not visible at the ports and is
    // not kept.
    logic [3:0] nib_px [NPIX];
    logic       bit_px [NPIX];
    logic [1:0] fb_mode;

    t_rsp       rsp_due [$];     // results owed by the core, oldest first
    int         err_cnt;
    bit         burst;           // back-to-back requests while set
    logic [7:0] last_x;
    logic [7:0] last_y;

    // one directed step: optional mode write, the request, and where the
    // answer is obvious, the typed-in result
    typedef struct {
        bit         set_mode;
        logic [1:0] mode;
        t_req       req;
        bit         typed;
        t_rsp       rsp;
    } t_dir_row;

    t_dir_row dir_tab [$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("framebuffer_pixel_rect_fill_core test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Framebuffer behavior
    // ------------------------------------------------------------------------
    function automatic void write_px(int x, int y, logic [3:0] c);
        if (fb_mode == MODE_NIBBLE) begin
            nib_px[y * COLS + x] = c;
        end else if (fb_mode == MODE_BIT) begin
            bit_px[y * COLS + x] = c[0];
        end
        // three-bit and undefined modes drop every write
    endfunction

    // Applies one request to the bench framebuffer and returns its result.
    function automatic t_rsp fb_apply(t_req r);
        t_rsp res;
        bit   s_ok;
        bit   e_ok;
        int   idx;
        res  = '0;
        s_ok = (r.x_start <= XM) && (r.y_start <= YM);
        e_ok = (r.x_end <= XM) && (r.y_end <= YM);
        idx  = int'(r.y_start) * COLS + int'(r.x_start);
        case (r.op)
            OP_DRAW: begin
                if (!s_ok) res.rejected = 1'b1;
                else write_px(int'(r.x_start), int'(r.y_start), r.pixel_color);
            end
            OP_READ: begin
                if (!s_ok) begin
                    res.rejected = 1'b1;
                end else if (fb_mode == MODE_NIBBLE) begin
                    res.read_color = nib_px[idx];
                end else if (fb_mode == MODE_BIT) begin
                    res.read_color = {3'b000, bit_px[idx]};
                end
            end
            OP_FILL: begin
                // any corner off screen rejects; a reversed span is empty
                if (!s_ok || !e_ok) begin
                    res.rejected = 1'b1;
                end else begin
                    for (int x = int'(r.x_start); x <= int'(r.x_end); x++) begin
                        for (int y = int'(r.y_start); y <= int'(r.y_end); y++) begin
                            write_px(x, y, r.pixel_color);
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Presents one request at a falling edge and holds it until the core
    // takes it (start high, busy low at a rising edge). The expectation is
    // queued at that edge, so it is in place well before the result strobe.
    task automatic issue(t_req r, bit typed, t_rsp typed_rsp);
        t_rsp pred;
        if ($urandom_range(0, 7) == 0) burst = !burst;
        if (!burst) repeat ($urandom_range(0, 15)) @(negedge i_clk);
        i_req = r;
        start = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = fb_apply(r);
        rsp_due.push_back(typed ? typed_rsp : pred);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Mode writes happen only with nothing in flight. Every request gives a
    // result, so an empty queue means the core is idle.
    task automatic write_mode(logic [1:0] m);
        while (rsp_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_data  = m;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        fb_mode = m;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic add_row(bit sm, logic [1:0] m, logic [1:0] op,
                           int xs, int ys, int xe, int ye, int col,
                           bit typed, int rc, int rej);
        t_dir_row row;
        row.set_mode            = sm;
        row.mode                = m;
        row.req.op              = op;
        row.req.x_start         = COORD_W'(xs);
        row.req.y_start         = COORD_W'(ys);
        row.req.x_end           = COORD_W'(xe);
        row.req.y_end           = COORD_W'(ye);
        row.req.pixel_color     = COLOR_W'(col);
        row.typed               = typed;
        row.rsp.read_color      = COLOR_W'(rc);
        row.rsp.rejected        = 1'(rej);
        dir_tab.push_back(row);
    endtask

    // Mostly on screen, with zero, the limit itself and some off-screen values.
    function automatic logic [7:0] pick_coord(int lim);
        int k;
        k = $urandom_range(0, 99);
        if (k < 8)  return COORD_W'($urandom_range(lim + 1, 255));
        if (k < 12) return 8'd0;
        if (k < 16) return COORD_W'(lim);
        return COORD_W'($urandom_range(0, lim));
    endfunction

    function automatic t_req make_req();
        t_req r;
        int   k;
        int   w;
        int   h;
        r.x_end       = COORD_W'($urandom);
        r.y_end       = COORD_W'($urandom);
        r.pixel_color = COLOR_W'($urandom);
        k             = $urandom_range(0, 99);
        if (k < 36) begin
            r.op      = OP_DRAW;
            r.x_start = pick_coord(XM);
            r.y_start = pick_coord(YM);
            if (r.x_start <= XM && r.y_start <= YM) begin
                last_x = r.x_start;
                last_y = r.y_start;
            end
        end else if (k < 72) begin
            // half the reads go back to the last pixel drawn
            r.op = OP_READ;
            if ($urandom_range(0, 1)) begin
                r.x_start = last_x;
                r.y_start = last_y;
            end else begin
                r.x_start = pick_coord(XM);
                r.y_start = pick_coord(YM);
            end
        end else if (k < 95) begin
            r.op = OP_FILL;
            if ($urandom_range(0, 63) == 0) begin
                // rare near-full-screen fill
                r.x_start = COORD_W'($urandom_range(0, 15));
                r.y_start = COORD_W'($urandom_range(0, 15));
                r.x_end   = COORD_W'($urandom_range(XM - 15, XM));
                r.y_end   = COORD_W'($urandom_range(YM - 15, YM));
            end else begin
                w         = $urandom_range(0, 7);
                h         = $urandom_range(0, 7);
                r.x_start = pick_coord(XM);
                r.y_start = pick_coord(YM);
                r.x_end   = (int'(r.x_start) + w > 255) ? 8'd255
                                                        : COORD_W'(int'(r.x_start) + w);
                r.y_end   = (int'(r.y_start) + h > 255) ? 8'd255
                                                        : COORD_W'(int'(r.y_start) + h);
                // reversed spans on either axis
                if ($urandom_range(0, 19) == 0 && r.x_start > 0)
                    r.x_end = COORD_W'(r.x_start - $urandom_range(1, r.x_start));
                if ($urandom_range(0, 19) == 0 && r.y_start > 0)
                    r.y_end = COORD_W'(r.y_start - $urandom_range(1, r.y_start));
            end
        end else begin
            r.op      = OP_NONE;
            r.x_start = COORD_W'($urandom);
            r.y_start = COORD_W'($urandom);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: the core cannot be stalled, so every strobe is taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (rsp_due.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("%0t: result with none pending: color %h rej %b",
                             $realtime, o_rsp.read_color, o_rsp.rejected);
            end else begin
                want = rsp_due.pop_front();
                if (o_done !== 1'b1 || o_rsp.read_color !== want.read_color ||
                    o_rsp.rejected !== want.rejected) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: mismatch: color %h/%h rej %b/%b (exp/got)",
                                 $realtime, want.read_color, o_rsp.read_color,
                                 want.rejected, o_rsp.rejected);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        int plen;
        int pm;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        fb_mode     = MODE_NIBBLE;
        err_cnt     = 0;
        burst       = 1'b0;
        last_x      = '0;
        last_y      = '0;

        // Directed table. The first rows run in the reset mode. Full-screen
        // fills early on leave both stores written everywhere, so later
        // reads never hit an unwritten pixel.
        //      mode write       op       xs   ys   xe   ye   col typed rc rej
        add_row(0, MODE_NIBBLE, OP_FILL,   0,   0, 175, 175, 'hA, 1,   0, 0);
        add_row(0, MODE_NIBBLE, OP_READ,   0,   0,   0,   0,    0, 1, 'hA, 0);
        add_row(0, MODE_NIBBLE, OP_READ, 175, 175, 255, 255,    0, 1, 'hA, 0);
        add_row(0, MODE_NIBBLE, OP_DRAW, 175,   0,   0,   0, 'hF, 1,   0, 0);
        add_row(0, MODE_NIBBLE, OP_READ, 175,   0,   0,   0,    0, 1, 'hF, 0);
        add_row(0, MODE_NIBBLE, OP_DRAW, 176,   0,   0,   0, 'hF, 1,   0, 1);
        add_row(0, MODE_NIBBLE, OP_READ,   0, 255,   0,   0,    0, 1,   0, 1);
        add_row(0, MODE_NIBBLE, OP_FILL,   0,   0, 176,   5, 'h3, 1,   0, 1);
        add_row(0, MODE_NIBBLE, OP_FILL,   0,   0,   5, 255, 'h3, 1,   0, 1);
        add_row(0, MODE_NIBBLE, OP_FILL,  10,  10,   5,  20, 'h5, 1,   0, 0);
        add_row(0, MODE_NIBBLE, OP_FILL,   5,   9,   6,   8, 'h5, 1,   0, 0);
        add_row(0, MODE_NIBBLE, OP_FILL,   3,   4,   3,   4,    0, 0,   0, 0);
        add_row(0, MODE_NIBBLE, OP_READ,   3,   4,   0,   0,    0, 0,   0, 0);
        add_row(0, MODE_NIBBLE, OP_NONE, 255, 255, 255, 255, 'hF, 1,   0, 0);
        // one-bit store keeps only the low color bit
        add_row(1, MODE_BIT,    OP_FILL,   0,   0, 175, 175, 'hB, 1,   0, 0);
        add_row(0, MODE_BIT,    OP_READ,   0,   0,   0,   0,    0, 1,   1, 0);
        add_row(0, MODE_BIT,    OP_DRAW,   5,   5,   0,   0, 'hE, 1,   0, 0);
        add_row(0, MODE_BIT,    OP_READ,   5,   5,   0,   0,    0, 1,   0, 0);
        add_row(0, MODE_BIT,    OP_READ, 175, 175,   0,   0,    0, 0,   0, 0);
        // three-bit mode: writes dropped, reads zero, range still checked
        add_row(1, MODE_TRIBIT, OP_DRAW,   1,   1,   0,   0, 'h7, 1,   0, 0);
        add_row(0, MODE_TRIBIT, OP_READ,   1,   1,   0,   0,    0, 1,   0, 0);
        add_row(0, MODE_TRIBIT, OP_DRAW, 200,   1,   0,   0, 'h7, 1,   0, 1);
        add_row(0, MODE_TRIBIT, OP_FILL,   0,   0, 175, 175, 'h9, 1,   0, 0);
        add_row(1, MODE_UNDEF,  OP_READ,  10,  10,   0,   0,    0, 1,   0, 0);
        add_row(1, MODE_NIBBLE, OP_READ, 175,   0,   0,   0,    0, 1, 'hF, 0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].set_mode) write_mode(dir_tab[i].mode);
            issue(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);
        end

        // Random phases, each under a freshly written mode. Most phases use
        // the two real stores; the no-op modes get a smaller share.
        sent = 0;
        while (sent < N_RND) begin
            pm = $urandom_range(0, 9);
            write_mode(pm < 4 ? MODE_NIBBLE : pm < 8 ? MODE_BIT :
                       pm == 8 ? MODE_TRIBIT : MODE_UNDEF);
            plen = $urandom_range(100, 250);
            for (int n = 0; n < plen && sent < N_RND; n++) begin
                issue(make_req(), 1'b0, '0);
                sent++;
            end
        end

        // drain, then watch a little longer for stray strobes
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("framebuffer_pixel_rect_fill_core test passed");
        end else begin
            $display("framebuffer_pixel_rect_fill_core test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/fbrf_pkg.sv
hdl/fbrf_ram.sv
hdl/framebuffer_pixel_rect_fill_core.sv
tb/framebuffer_pixel_rect_fill_core_tb.sv
